// ===== hdl/piwc_pkg.sv =====
// Package for the particle integrate and wall collide block.
// Holds register indexes, reset values and the rounding and saturation helpers.
// No dependencies.
package piwc_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned QW       = 16;
  localparam int unsigned RadiusW  = 21;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned ProdW    = 50;
  localparam int unsigned Latency  = 11;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t RegTimeStep    = 4'd0;
  localparam cfg_idx_t RegRestitution = 4'd1;
  localparam cfg_idx_t RegRadius      = 4'd2;
  localparam cfg_idx_t RegMinX        = 4'd3;
  localparam cfg_idx_t RegMinY        = 4'd4;
  localparam cfg_idx_t RegMinZ        = 4'd5;
  localparam cfg_idx_t RegMaxX        = 4'd6;
  localparam cfg_idx_t RegMaxY        = 4'd7;

  localparam logic [QW-1:0]           TimeStepRst    = 16'd546;
  localparam logic [QW-1:0]           RestitutionRst = 16'd3277;
  localparam logic [RadiusW-1:0]      RadiusRst      = 21'd13107;
  localparam logic signed [DataW-1:0] MinRst         = 32'sd0;
  localparam logic signed [DataW-1:0] MaxRst         = 32'sd1048576;

  localparam logic signed [DataW-1:0] SatMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] SatMin = {1'b1, {(DataW-1){1'b0}}};

  // round half up, drop the Q0.16 fraction, saturate to 32 bits
  function automatic logic signed [DataW-1:0] rnd_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW-1:0] t;
    logic signed [ProdW-1:0] sh;
    t  = p + (ProdW'(1) <<< (QW - 1));
    sh = t >>> QW;
    if (!sh[ProdW-1] && (|sh[ProdW-2:DataW-1])) begin
      return SatMax;
    end else if (sh[ProdW-1] && !(&sh[ProdW-2:DataW-1])) begin
      return SatMin;
    end
    return sh[DataW-1:0];
  endfunction

  function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] s);
    if (s[DataW] != s[DataW-1]) begin
      return s[DataW] ? SatMin : SatMax;
    end
    return s[DataW-1:0];
  endfunction

endpackage

// ===== hdl/particle_integrate_wall_collide.sv =====
// Top level of the particle integrate and wall collide block.
// Depends on piwc_pkg and piwc_axis; holds the configuration registers.
//
//  channel   handshake                  payload
//  -------   -------------------------  --------------------------------------
//  input     start_i, busy_o            pos_*_i, vel_*_i, acc_*_i
//  result    done_o (one-cycle strobe)  new_pos_*_o, new_vel_*_o
//  config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle; each result appears once its item has passed through
// the eleven-stage axis pipeline (two multiplies for integration, each followed
// by rounding and a sum, and two for the bounce on opposing walls, each rounded).
// busy_o stays low and cfg_ready_o high. Reset clears the valid chain and
// loads the register defaults. The receiver cannot stall, so the pipeline never holds.
module particle_integrate_wall_collide (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [piwc_pkg::DataW-1:0]  pos_x_i,
  input  logic signed [piwc_pkg::DataW-1:0]  pos_y_i,
  input  logic signed [piwc_pkg::DataW-1:0]  pos_z_i,
  input  logic signed [piwc_pkg::DataW-1:0]  vel_x_i,
  input  logic signed [piwc_pkg::DataW-1:0]  vel_y_i,
  input  logic signed [piwc_pkg::DataW-1:0]  vel_z_i,
  input  logic signed [piwc_pkg::DataW-1:0]  acc_x_i,
  input  logic signed [piwc_pkg::DataW-1:0]  acc_y_i,
  input  logic signed [piwc_pkg::DataW-1:0]  acc_z_i,
  output logic                               done_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_pos_x_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_pos_y_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_pos_z_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_vel_x_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_vel_y_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_vel_z_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  piwc_pkg::cfg_idx_t                 cfg_index_i,
  input  logic [piwc_pkg::DataW-1:0]         cfg_data_i
);

  localparam int unsigned W  = piwc_pkg::DataW;
  localparam int unsigned QW = piwc_pkg::QW;
  localparam int unsigned RW = piwc_pkg::RadiusW;
  localparam int unsigned L  = piwc_pkg::Latency;

  logic [QW-1:0]       time_step_q, restitution_q;
  logic [RW-1:0]       radius_q;
  logic signed [W-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q;
  logic signed [W-1:0] lo_x_q, lo_y_q, lo_z_q, hi_x_q, hi_y_q;
  logic signed [W:0]   rad_ext;
  logic [L-1:0]        valid_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign rad_ext     = $signed({{(W + 1 - RW){1'b0}}, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q   <= piwc_pkg::TimeStepRst;
      restitution_q <= piwc_pkg::RestitutionRst;
      radius_q      <= piwc_pkg::RadiusRst;
      min_x_q       <= piwc_pkg::MinRst;
      min_y_q       <= piwc_pkg::MinRst;
      min_z_q       <= piwc_pkg::MinRst;
      max_x_q       <= piwc_pkg::MaxRst;
      max_y_q       <= piwc_pkg::MaxRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        piwc_pkg::RegTimeStep:    time_step_q   <= cfg_data_i[QW-1:0];
        piwc_pkg::RegRestitution: restitution_q <= cfg_data_i[QW-1:0];
        piwc_pkg::RegRadius:      radius_q      <= cfg_data_i[RW-1:0];
        piwc_pkg::RegMinX:        min_x_q       <= cfg_data_i;
        piwc_pkg::RegMinY:        min_y_q       <= cfg_data_i;
        piwc_pkg::RegMinZ:        min_z_q       <= cfg_data_i;
        piwc_pkg::RegMaxX:        max_x_q       <= cfg_data_i;
        piwc_pkg::RegMaxY:        max_y_q       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold inset wall limits
  always_ff @(posedge clk_i) begin
    lo_x_q <= piwc_pkg::sat33({min_x_q[W-1], min_x_q} + rad_ext);
    lo_y_q <= piwc_pkg::sat33({min_y_q[W-1], min_y_q} + rad_ext);
    lo_z_q <= piwc_pkg::sat33({min_z_q[W-1], min_z_q} + rad_ext);
    hi_x_q <= piwc_pkg::sat33({max_x_q[W-1], max_x_q} - rad_ext);
    hi_y_q <= piwc_pkg::sat33({max_y_q[W-1], max_y_q} - rad_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[L-2:0], start_i};
    end
  end

  assign done_o = valid_q[L-1];

  piwc_axis u_axis_x (
    .clk_i         (clk_i),
    .time_step_i   (time_step_q),
    .restitution_i (restitution_q),
    .lim_lo_i      (lo_x_q),
    .lim_hi_i      (hi_x_q),
    .hi_en_i       (1'b1),
    .pos_i         (pos_x_i),
    .vel_i         (vel_x_i),
    .acc_i         (acc_x_i),
    .new_pos_o     (new_pos_x_o),
    .new_vel_o     (new_vel_x_o)
  );

  piwc_axis u_axis_y (
    .clk_i         (clk_i),
    .time_step_i   (time_step_q),
    .restitution_i (restitution_q),
    .lim_lo_i      (lo_y_q),
    .lim_hi_i      (hi_y_q),
    .hi_en_i       (1'b1),
    .pos_i         (pos_y_i),
    .vel_i         (vel_y_i),
    .acc_i         (acc_y_i),
    .new_pos_o     (new_pos_y_o),
    .new_vel_o     (new_vel_y_o)
  );

  // open top: no upper wall on z
  piwc_axis u_axis_z (
    .clk_i         (clk_i),
    .time_step_i   (time_step_q),
    .restitution_i (restitution_q),
    .lim_lo_i      (lo_z_q),
    .lim_hi_i      (piwc_pkg::SatMax),
    .hi_en_i       (1'b0),
    .pos_i         (pos_z_i),
    .vel_i         (vel_z_i),
    .acc_i         (acc_z_i),
    .new_pos_o     (new_pos_z_o),
    .new_vel_o     (new_vel_z_o)
  );

endmodule

// ===== hdl/piwc_axis.sv =====
// One axis of the integrate and collide pipeline: eleven register stages.
// Depends on piwc_pkg for widths and the rounding and saturation helpers.
module piwc_axis (
  input  logic                               clk_i,
  input  logic [piwc_pkg::QW-1:0]            time_step_i,
  input  logic [piwc_pkg::QW-1:0]            restitution_i,
  input  logic signed [piwc_pkg::DataW-1:0]  lim_lo_i,
  input  logic signed [piwc_pkg::DataW-1:0]  lim_hi_i,
  input  logic                               hi_en_i,
  input  logic signed [piwc_pkg::DataW-1:0]  pos_i,
  input  logic signed [piwc_pkg::DataW-1:0]  vel_i,
  input  logic signed [piwc_pkg::DataW-1:0]  acc_i,
  output logic signed [piwc_pkg::DataW-1:0]  new_pos_o,
  output logic signed [piwc_pkg::DataW-1:0]  new_vel_o
);

  localparam int unsigned W  = piwc_pkg::DataW;
  localparam int unsigned PW = piwc_pkg::ProdW;

  logic signed [PW-2:0] acc_prod_q;
  logic signed [W-1:0]  pos1_q, vel1_q;
  logic signed [W-1:0]  dv_q, pos2_q, vel2_q;
  logic signed [W-1:0]  v3_q, pos3_q;
  logic signed [PW-2:0] vel_prod_q;
  logic signed [W-1:0]  pos4_q, v4_q;
  logic signed [W-1:0]  dp_q, pos5_q, v5_q;
  logic signed [W-1:0]  p6_q, v6_q;
  logic signed [W-1:0]  p7_d, p7_q, v7_q;
  logic signed [W-1:0]  p_lo;
  logic                 lo_hit, hi_hit;
  logic                 b1_7_q, hien_7_q;
  logic signed [PW-1:0] bprod1_q;
  logic signed [W-1:0]  p8_q, v8_q;
  logic                 b1_8_q, hien_8_q;
  logic signed [W-1:0]  p9_q, v9_q;
  logic                 hien_9_q;
  logic signed [PW-1:0] bprod2_q;
  logic signed [W-1:0]  p10_q, v10_q;
  logic                 b2_10_q;
  logic signed [W-1:0]  p11_q, v11_q;

  always_comb begin
    lo_hit = (p6_q < lim_lo_i);
    p_lo   = lo_hit ? lim_lo_i : p6_q;
    hi_hit = hi_en_i && (p_lo > lim_hi_i);
    p7_d   = hi_hit ? lim_hi_i : p_lo;
  end

  always_ff @(posedge clk_i) begin
    acc_prod_q <= acc_i * $signed({1'b0, time_step_i});
    pos1_q     <= pos_i;
    vel1_q     <= vel_i;

    dv_q   <= piwc_pkg::rnd_sat({acc_prod_q[PW-2], acc_prod_q});
    pos2_q <= pos1_q;
    vel2_q <= vel1_q;

    v3_q   <= piwc_pkg::sat33({vel2_q[W-1], vel2_q} + {dv_q[W-1], dv_q});
    pos3_q <= pos2_q;

    vel_prod_q <= v3_q * $signed({1'b0, time_step_i});
    pos4_q     <= pos3_q;
    v4_q       <= v3_q;

    dp_q   <= piwc_pkg::rnd_sat({vel_prod_q[PW-2], vel_prod_q});
    pos5_q <= pos4_q;
    v5_q   <= v4_q;

    p6_q <= piwc_pkg::sat33({pos5_q[W-1], pos5_q} + {dp_q[W-1], dp_q});
    v6_q <= v5_q;

    p7_q     <= p7_d;
    v7_q     <= v6_q;
    b1_7_q   <= lo_hit && v6_q[W-1];
    hien_7_q <= hi_hit;

    bprod1_q <= (-$signed({v7_q[W-1], v7_q})) * $signed({1'b0, restitution_i});
    p8_q     <= p7_q;
    v8_q     <= v7_q;
    b1_8_q   <= b1_7_q;
    hien_8_q <= hien_7_q;

    v9_q     <= b1_8_q ? piwc_pkg::rnd_sat(bprod1_q) : v8_q;
    p9_q     <= p8_q;
    hien_9_q <= hien_8_q;

    bprod2_q <= (-$signed({v9_q[W-1], v9_q})) * $signed({1'b0, restitution_i});
    b2_10_q  <= hien_9_q && !v9_q[W-1] && (|v9_q);
    p10_q    <= p9_q;
    v10_q    <= v9_q;

    v11_q <= b2_10_q ? piwc_pkg::rnd_sat(bprod2_q) : v10_q;
    p11_q <= p10_q;
  end

  assign new_pos_o = p11_q;
  assign new_vel_o = v11_q;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for particle_integrate_wall_collide: directed and random particles
// checked field by field against a built-in integrate and wall bounce predictor.
// Depends on piwc_pkg for register indexes, reset values and the pipeline latency.
module tb_top;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PrintLimit = 50;
  localparam int          RegSpareLo = 8;
  localparam int          RegSpareHi = 15;
  localparam logic [31:0] WordMax    = 32'h7fff_ffff;
  localparam logic [31:0] WordMin    = 32'h8000_0000;
  localparam logic [31:0] Unit       = 32'h0001_0000;
  localparam logic [31:0] Gravity    = -32'sd642253;
  localparam logic [15:0] QHalf      = 16'd32768;
  localparam logic [15:0] QFull      = 16'd65535;
  localparam logic [20:0] InsetMax   = 21'd1048576;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
    logic [2:0][31:0] acc;
  } particle_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] vel;
  } motion_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start_i = 1'b0;
  logic                        busy_o;
  logic [piwc_pkg::DataW-1:0]  pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [piwc_pkg::DataW-1:0]  vel_x_i = '0, vel_y_i = '0, vel_z_i = '0;
  logic [piwc_pkg::DataW-1:0]  acc_x_i = '0, acc_y_i = '0, acc_z_i = '0;
  logic                        done_o;
  logic [piwc_pkg::DataW-1:0]  new_pos_x_o, new_pos_y_o, new_pos_z_o;
  logic [piwc_pkg::DataW-1:0]  new_vel_x_o, new_vel_y_o, new_vel_z_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  piwc_pkg::cfg_idx_t          cfg_index_i = '0;
  logic [piwc_pkg::DataW-1:0]  cfg_data_i = '0;

  logic [15:0]       step_q;
  logic [15:0]       bounce_q;
  logic [20:0]       inset;
  logic [31:0]       wall_lo [3];
  logic [31:0]       wall_hi [2];

  motion_t           pending_motion [$];
  motion_t           head;
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  int unsigned       burst_left = 1;
  bit                sender_on = 1'b0;

  particle_integrate_wall_collide u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .pos_z_i     (pos_z_i),
    .vel_x_i     (vel_x_i),
    .vel_y_i     (vel_y_i),
    .vel_z_i     (vel_z_i),
    .acc_x_i     (acc_x_i),
    .acc_y_i     (acc_y_i),
    .acc_z_i     (acc_z_i),
    .done_o      (done_o),
    .new_pos_x_o (new_pos_x_o),
    .new_pos_y_o (new_pos_y_o),
    .new_pos_z_o (new_pos_z_o),
    .new_vel_x_o (new_vel_x_o),
    .new_vel_y_o (new_vel_y_o),
    .new_vel_z_o (new_vel_z_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) begin
      return 64'sd2147483647;
    end else if (v < -64'sd2147483648) begin
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint as_word(logic [31:0] w);
    longint r;
    r = $signed(w);
    return r;
  endfunction

  function automatic longint scale_q16(longint a, logic [15:0] q);
    longint qq;
    longint p;
    qq = q;
    p  = a * qq + 64'sd32768;
    return clamp_word(p >>> 16);
  endfunction

  function automatic motion_t predict_motion(particle_t it);
    longint  p;
    longint  v;
    longint  lim;
    longint  r;
    motion_t res;
    int      i;
    r = inset;
    for (i = 0; i < 3; i++) begin
      v   = clamp_word(as_word(it.vel[i]) + scale_q16(as_word(it.acc[i]), step_q));
      p   = clamp_word(as_word(it.pos[i]) + scale_q16(v, step_q));
      lim = clamp_word(as_word(wall_lo[i]) + r);
      if (p < lim) begin
        p = lim;
        if (v < 0) v = scale_q16(-v, bounce_q);
      end
      if (i < 2) begin
        lim = clamp_word(as_word(wall_hi[i]) - r);
        if (p > lim) begin
          p = lim;
          if (v > 0) v = scale_q16(-v, bounce_q);
        end
      end
      res.pos[i] = p[31:0];
      res.vel[i] = v[31:0];
    end
    return res;
  endfunction

  function automatic void apply_reg(piwc_pkg::cfg_idx_t idx, logic [31:0] data);
    case (idx)
      piwc_pkg::RegTimeStep:    step_q     = data[15:0];
      piwc_pkg::RegRestitution: bounce_q   = data[15:0];
      piwc_pkg::RegRadius:      inset      = data[20:0];
      piwc_pkg::RegMinX:        wall_lo[0] = data;
      piwc_pkg::RegMinY:        wall_lo[1] = data;
      piwc_pkg::RegMinZ:        wall_lo[2] = data;
      piwc_pkg::RegMaxX:        wall_hi[0] = data;
      piwc_pkg::RegMaxY:        wall_hi[1] = data;
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] near_word(longint base, int unsigned reach);
    longint t;
    t = clamp_word(base + longint'($urandom_range(0, 2 * reach)) - longint'(reach));
    return t[31:0];
  endfunction

  function automatic particle_t make_particle(logic [31:0] px, logic [31:0] py,
                                              logic [31:0] pz, logic [31:0] vx,
                                              logic [31:0] vy, logic [31:0] vz,
                                              logic [31:0] ax, logic [31:0] ay,
                                              logic [31:0] az);
    particle_t it;
    it.pos = {pz, py, px};
    it.vel = {vz, vy, vx};
    it.acc = {az, ay, ax};
    return it;
  endfunction

  // mostly particles near a wall with moderate motion, some pure noise
  function automatic particle_t random_particle();
    particle_t   it;
    int unsigned kind;
    int unsigned reach;
    int          i;
    reach = inset + (1 << 18);
    for (i = 0; i < 3; i++) begin
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        it.pos[i] = $urandom;
        it.vel[i] = $urandom;
        it.acc[i] = $urandom;
      end else begin
        if (kind < 4) begin
          it.pos[i] = near_word(as_word(wall_lo[i]), reach);
        end else if (i < 2 && kind < 7) begin
          it.pos[i] = near_word(as_word(wall_hi[i]), reach);
        end else begin
          it.pos[i] = near_word(as_word(wall_lo[i]), 1 << 21);
        end
        it.vel[i] = ($urandom_range(0, 9) == 0) ? $urandom : near_word(0, 1 << 21);
        it.acc[i] = near_word(0, 1 << 23);
      end
    end
    return it;
  endfunction

  function automatic logic [31:0] span_above(logic [31:0] lo);
    longint t;
    t = clamp_word(as_word(lo) + longint'($urandom_range(1 << 18, 1 << 23)));
    return t[31:0];
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < PrintLimit) begin
      $display("mismatch %s: got %h want %h", what, got, want);
    end
    mismatches++;
  endtask

  task automatic drive_fields(particle_t it);
    pos_x_i <= it.pos[0];
    pos_y_i <= it.pos[1];
    pos_z_i <= it.pos[2];
    vel_x_i <= it.vel[0];
    vel_y_i <= it.vel[1];
    vel_z_i <= it.vel[2];
    acc_x_i <= it.acc[0];
    acc_y_i <= it.acc[1];
    acc_z_i <= it.acc[2];
  endtask

  task automatic hold_off(int unsigned n);
    particle_t junk;
    int        i;
    for (i = 0; i < 3; i++) begin
      junk.pos[i] = $urandom;
      junk.vel[i] = $urandom;
      junk.acc[i] = $urandom;
    end
    start_i   <= 1'b0;
    sender_on  = 1'b0;
    drive_fields(junk);
    repeat (n) @(posedge clk_i);
  endtask

  task automatic pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      hold_off($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
  endtask

  task automatic send_item(particle_t it);
    start_i   <= 1'b1;
    sender_on  = 1'b1;
    drive_fields(it);
    do @(posedge clk_i); while (busy_o);
    pending_motion = {pending_motion, predict_motion(it)};
    pace();
  endtask

  task automatic send_random(int unsigned n);
    repeat (n) send_item(random_particle());
  endtask

  task automatic drain();
    if (sender_on) hold_off(1);
    while (pending_motion.size() != 0) @(posedge clk_i);
    repeat (piwc_pkg::Latency) @(posedge clk_i);
  endtask

  task automatic write_reg(piwc_pkg::cfg_idx_t idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [15:0] ts, logic [15:0] rest, logic [20:0] rad,
                           logic [31:0] lox, logic [31:0] loy, logic [31:0] loz,
                           logic [31:0] hix, logic [31:0] hiy);
    drain();
    write_reg(piwc_pkg::RegTimeStep, {16'd0, ts});
    write_reg(piwc_pkg::RegRestitution, {16'd0, rest});
    write_reg(piwc_pkg::RegRadius, {11'd0, rad});
    write_reg(piwc_pkg::RegMinX, lox);
    write_reg(piwc_pkg::RegMinY, loy);
    write_reg(piwc_pkg::RegMinZ, loz);
    write_reg(piwc_pkg::RegMaxX, hix);
    write_reg(piwc_pkg::RegMaxY, hiy);
  endtask

  task automatic test_default_settings();
    send_item(make_particle(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_particle(WordMax, WordMax, WordMax, WordMax, WordMax, WordMax,
                            WordMax, WordMax, WordMax));
    send_item(make_particle(WordMin, WordMin, WordMin, WordMin, WordMin, WordMin,
                            WordMin, WordMin, WordMin));
    send_item(make_particle(8 * Unit, 8 * Unit, 8 * Unit, Unit, -Unit, 2 * Unit,
                            0, 0, Gravity));
    send_item(make_particle(8 * Unit, 8 * Unit, 32'd6554, 0, 0, -2 * Unit,
                            0, 0, Gravity));
    send_item(make_particle(32'd3277, 8 * Unit, 8 * Unit, -3 * Unit, 0, 0, 0, 0, 0));
    send_item(make_particle(32'd1045299, 8 * Unit, 8 * Unit, 3 * Unit, 0, 0, 0, 0, 0));
    send_item(make_particle(8 * Unit, 32'd3277, 8 * Unit, 0, -3 * Unit, 0, 0, 0, 0));
    send_item(make_particle(8 * Unit, 32'd1045299, 8 * Unit, 0, 3 * Unit, 0, 0, 0, 0));
    send_item(make_particle(0, 16 * Unit, -Unit, Unit / 2, -Unit / 2, Unit,
                            WordMin, WordMax, 0));
  endtask

  task automatic test_rounding_ties();
    drain();
    write_reg(piwc_pkg::RegTimeStep, {16'd0, QHalf});
    write_reg(piwc_pkg::RegRestitution, {16'd0, QHalf});
    send_item(make_particle(8 * Unit, 8 * Unit, 8 * Unit, 0, 0, 0, 1, -1, 3));
    send_item(make_particle(8 * Unit, 8 * Unit, 8 * Unit, 0, 0, 0, -3, 5, -5));
    send_item(make_particle(8 * Unit, 8 * Unit, 0, 0, 0, -3, 0, 0, 0));
  endtask

  task automatic test_inverted_walls();
    drain();
    write_reg(piwc_pkg::RegRadius, 0);
    write_reg(piwc_pkg::RegMinX, 10 * Unit);
    write_reg(piwc_pkg::RegMaxX, 6 * Unit);
    write_reg(piwc_pkg::RegMinY, 4 * Unit);
    write_reg(piwc_pkg::RegMaxY, -4 * Unit);
    send_item(make_particle(8 * Unit, 0, 8 * Unit, -Unit, -Unit, 0, 0, 0, 0));
    send_item(make_particle(12 * Unit, 5 * Unit, 8 * Unit, Unit, Unit, 0, 0, 0, 0));
    send_item(make_particle(8 * Unit, 0, 8 * Unit, 0, 0, 0, 0, 0, 0));
    send_random(20);
  endtask

  task automatic test_register_extremes();
    write_all(0, 0, 0, WordMin, WordMin, WordMin, WordMax, WordMax);
    send_item(make_particle(WordMax, WordMin, WordMax, WordMax, WordMin, WordMin,
                            WordMax, WordMin, WordMin));
    send_item(make_particle(WordMin, WordMax, WordMin, WordMin, WordMax, WordMax,
                            WordMin, WordMax, WordMax));
    send_random(30);
    write_all(QFull, QFull, InsetMax, WordMax, WordMax, WordMax, WordMin, WordMin);
    send_item(make_particle(0, 0, 0, Unit, -Unit, Unit, 0, 0, 0));
    send_item(make_particle(WordMax, WordMin, WordMax, WordMax, WordMin, WordMin,
                            WordMin, WordMax, WordMin));
    send_random(30);
    write_all(QFull, QFull, InsetMax, WordMin, WordMin, WordMin, WordMax, WordMax);
    send_item(make_particle(WordMin, WordMax, WordMin, WordMin, WordMax, WordMin,
                            WordMin, WordMax, WordMin));
    send_item(make_particle(WordMax, WordMin, WordMax, WordMax, WordMin, WordMax,
                            WordMax, WordMin, WordMax));
    send_random(30);
  endtask

  task automatic test_unknown_index();
    int k;
    drain();
    for (k = RegSpareLo; k <= RegSpareHi; k++) begin
      write_reg(piwc_pkg::cfg_idx_t'(k), $urandom);
    end
    send_item(make_particle(0, 16 * Unit, 0, -Unit, Unit, -Unit, 0, 0, 0));
    send_random(20);
  endtask

  task automatic test_random_settings();
    int unsigned phase;
    logic [31:0] lox, loy, loz;
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: begin
          lox = near_word(0, 1 << 22);
          loy = near_word(0, 1 << 22);
          loz = near_word(0, 1 << 22);
          write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 1048576), lox, loy, loz,
                    span_above(lox), span_above(loy));
        end
        1: begin
          write_all($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 1048576), $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        end
        default: begin
          lox = near_word(0, 1 << 24);
          loy = near_word(0, 1 << 24);
          loz = near_word(0, 1 << 24);
          write_all($urandom_range(0, 2048), $urandom_range(0, 65535),
                    $urandom_range(0, 65536), lox, loy, loz,
                    span_above(lox), span_above(loy));
        end
      endcase
      send_random(80);
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_motion.size() == 0) begin
        report_mismatch("result with no item pending", new_pos_x_o, 0);
      end else begin
        head = pending_motion.pop_front();
        if (new_pos_x_o !== head.pos[0]) report_mismatch("new_pos_x", new_pos_x_o, head.pos[0]);
        if (new_pos_y_o !== head.pos[1]) report_mismatch("new_pos_y", new_pos_y_o, head.pos[1]);
        if (new_pos_z_o !== head.pos[2]) report_mismatch("new_pos_z", new_pos_z_o, head.pos[2]);
        if (new_vel_x_o !== head.vel[0]) report_mismatch("new_vel_x", new_vel_x_o, head.vel[0]);
        if (new_vel_y_o !== head.vel[1]) report_mismatch("new_vel_y", new_vel_y_o, head.vel[1]);
        if (new_vel_z_o !== head.vel[2]) report_mismatch("new_vel_z", new_vel_z_o, head.vel[2]);
      end
    end
  end

  initial begin
    step_q     = piwc_pkg::TimeStepRst;
    bounce_q   = piwc_pkg::RestitutionRst;
    inset      = piwc_pkg::RadiusRst;
    wall_lo[0] = piwc_pkg::MinRst;
    wall_lo[1] = piwc_pkg::MinRst;
    wall_lo[2] = piwc_pkg::MinRst;
    wall_hi[0] = piwc_pkg::MaxRst;
    wall_hi[1] = piwc_pkg::MaxRst;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_default_settings();
    test_rounding_ties();
    test_inverted_walls();
    test_register_extremes();
    test_unknown_index();
    test_random_settings();
    drain();

    if (pending_motion.size() != 0) begin
      report_mismatch("results never arrived", pending_motion.size(), 0);
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
